### src/svf_pkg.sv
// Shared constants and control types for the state-variable filter.
// No dependencies; compile first.
package svf_pkg;

  // Default data format: signed samples with fraction bits.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 15;

  // Coefficient register widths, fixed by the register map.
  localparam int FREQ_W = 17;
  localparam int DAMP_W = 31;
  localparam int CFG_W  = 31;
  localparam int CFG_ADDR_W = 1;

  // Register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_FREQ = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_DAMP = 1'b1;

  // Reset values of the coefficients (damping of 1.0 in Q15).
  localparam logic [FREQ_W-1:0] FREQ_RESET = '0;
  localparam logic [DAMP_W-1:0] DAMP_RESET = DAMP_W'(32768);

  // Control of the shared multiplier for one step.
  typedef struct packed {
    logic hi_sel;   // multiply the upper half of the data operand
    logic load_lo;  // load the registered low partial product into the accumulator
    logic add_hi;   // add the registered high partial product, shifted
  } mul_ctrl_t;

endpackage

### src/svf_if.sv
// Valid/ready channels for the state-variable filter: sample in, results out.
// Depends on nothing; compile after svf_pkg.
interface svf_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface svf_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] highpass_out;
  logic signed [DATA_WIDTH-1:0] bandpass_out;
  logic signed [DATA_WIDTH-1:0] lowpass_out;

  modport source (output valid, output highpass_out, output bandpass_out,
                  output lowpass_out, input ready);
  modport sink   (input valid, input highpass_out, input bandpass_out,
                  input lowpass_out, output ready);
endinterface

### src/state_variable_filter_q15_top.sv
// Top level of the Chamberlin state-variable filter.
// Depends on svf_pkg, svf_if (channels) and svf_mul (shared multiplier).
//
// Each accepted sample item gives one result item with the highpass, bandpass
// and lowpass outputs of a Chamberlin state-variable filter in signed fixed
// point (FRAC_BITS fraction bits): high = x - low_prev - Q1*band_prev,
// band = F1*high + band_prev, low = F1*band + low_prev. Products are floored
// after the fraction shift and every sum and product saturates to the data
// range. F1 (freq_coeff, index 0) and Q1 (damping_coeff, index 1) are written
// through the config port; the user must write them only while the filter is
// idle, as the block itself does not enforce this. Reset sets them to 0 and
// 1.0 and clears the filter state. The three multiplies run one after another
// on a single shared multiplier that builds each product from two half-width
// partial products: each multiply runs a low, a high and an accumulate step,
// and each is followed by an add step that forms high, band or low in turn
// (the x - low_prev difference rides along with the first multiply). A new
// sample is taken only once the result is loaded; a result still waiting
// when the next one is ready holds the sequencer in its last step. The result
// sits in an output register, so a new sample is accepted while the previous
// result still waits to be taken.
module state_variable_filter_q15_top #(
  parameter int DATA_WIDTH = svf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = svf_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  svf_in_if.sink                           in_ch,
  svf_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [svf_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [svf_pkg::CFG_W-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_DAMP,
    S_HIGH,
    S_MUL_BAND,
    S_BAND,
    S_MUL_LOW,
    S_LOW
  } state_t;

  // Steps of one multiply on the shared unit.
  typedef enum logic [1:0] {
    STEP_LO,
    STEP_HI,
    STEP_ACC
  } step_t;

  state_t state;
  step_t  step;

  logic [svf_pkg::FREQ_W-1:0] freq_coeff;
  logic [svf_pkg::DAMP_W-1:0] damping_coeff;

  logic signed [DATA_WIDTH-1:0] x_reg;
  logic signed [DATA_WIDTH-1:0] diff;
  logic signed [DATA_WIDTH-1:0] high;
  logic signed [DATA_WIDTH-1:0] band;
  logic signed [DATA_WIDTH-1:0] band_prev;
  logic signed [DATA_WIDTH-1:0] low_prev;
  logic signed [DATA_WIDTH-1:0] high_out;
  logic signed [DATA_WIDTH-1:0] band_out;
  logic signed [DATA_WIDTH-1:0] low_out;
  logic                         out_valid;

  svf_pkg::mul_ctrl_t           mul_ctrl;
  logic signed [DATA_WIDTH-1:0] mul_data;
  logic [svf_pkg::CFG_W-1:0]    mul_coeff;
  logic signed [DATA_WIDTH-1:0] mul_result;

  logic signed [DATA_WIDTH-1:0] diff_next;
  logic signed [DATA_WIDTH-1:0] high_next;
  logic signed [DATA_WIDTH-1:0] band_next;
  logic signed [DATA_WIDTH-1:0] low_next;
  logic                         in_take;
  logic                         out_take;
  logic                         out_free;
  logic                         mul_busy;

  // Clamp a one-bit-grown sum back to the data range.
  function automatic logic signed [DATA_WIDTH-1:0] sat_sum(
    input logic signed [DATA_WIDTH:0] v
  );
    if (v[DATA_WIDTH] != v[DATA_WIDTH-1]) begin
      return $signed({v[DATA_WIDTH], {(DATA_WIDTH-1){~v[DATA_WIDTH]}}});
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  assign in_ch.ready         = (state == S_IDLE);
  assign in_take             = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.highpass_out = high_out;
  assign out_ch.bandpass_out = band_out;
  assign out_ch.lowpass_out  = low_out;
  assign out_take            = out_valid && out_ch.ready;
  // The output register may be reloaded when empty or emptied this cycle.
  assign out_free            = !out_valid || out_ch.ready;

  // Adders: each one grows by a bit, then saturates.
  assign diff_next = sat_sum({x_reg[DATA_WIDTH-1], x_reg}
                             - {low_prev[DATA_WIDTH-1], low_prev});
  assign high_next = sat_sum({diff[DATA_WIDTH-1], diff}
                             - {mul_result[DATA_WIDTH-1], mul_result});
  assign band_next = sat_sum({mul_result[DATA_WIDTH-1], mul_result}
                             + {band_prev[DATA_WIDTH-1], band_prev});
  assign low_next  = sat_sum({mul_result[DATA_WIDTH-1], mul_result}
                             + {low_prev[DATA_WIDTH-1], low_prev});

  // Steer the shared multiplier: Q1*band_prev, then F1*high, then F1*band.
  always_comb begin
    mul_busy = (state == S_MUL_DAMP) || (state == S_MUL_BAND)
               || (state == S_MUL_LOW);
    case (state)
      S_MUL_DAMP: begin
        mul_data  = band_prev;
        mul_coeff = damping_coeff;
      end
      S_MUL_BAND: begin
        mul_data  = high;
        mul_coeff = svf_pkg::CFG_W'(freq_coeff);
      end
      default: begin
        mul_data  = band;
        mul_coeff = svf_pkg::CFG_W'(freq_coeff);
      end
    endcase
    mul_ctrl.hi_sel  = mul_busy && (step == STEP_HI);
    mul_ctrl.load_lo = mul_busy && (step == STEP_HI);
    mul_ctrl.add_hi  = mul_busy && (step == STEP_ACC);
  end

  svf_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .ctrl   (mul_ctrl),
    .data   (mul_data),
    .coeff  (mul_coeff),
    .result (mul_result)
  );

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_coeff    <= svf_pkg::FREQ_RESET;
      damping_coeff <= svf_pkg::DAMP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        svf_pkg::REG_FREQ: freq_coeff    <= cfg_data[svf_pkg::FREQ_W-1:0];
        svf_pkg::REG_DAMP: damping_coeff <= cfg_data[svf_pkg::DAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, filter state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_LO;
      band_prev <= '0;
      low_prev  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a new result, or drop valid once the waiting one is taken.
      if (state == S_LOW && out_free) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            x_reg <= in_ch.sample_in;
            step  <= STEP_LO;
            state <= S_MUL_DAMP;
          end
        end
        S_MUL_DAMP, S_MUL_BAND, S_MUL_LOW: begin
          // The x - low_prev difference rides along with the first multiply.
          if (state == S_MUL_DAMP && step == STEP_LO) begin
            diff <= diff_next;
          end
          case (step)
            STEP_LO: step <= STEP_HI;
            STEP_HI: step <= STEP_ACC;
            default: begin
              step <= STEP_LO;
              case (state)
                S_MUL_DAMP: state <= S_HIGH;
                S_MUL_BAND: state <= S_BAND;
                default:    state <= S_LOW;
              endcase
            end
          endcase
        end
        S_HIGH: begin
          high  <= high_next;
          state <= S_MUL_BAND;
        end
        S_BAND: begin
          band  <= band_next;
          state <= S_MUL_LOW;
        end
        S_LOW: begin
          // Hold here until the previous result has been taken.
          if (out_free) begin
            high_out  <= high;
            band_out  <= band;
            low_out   <= low_next;
            band_prev <= band;
            low_prev  <= low_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/svf_mul.sv
// Shared coefficient multiplier: two half-width partial products, accumulated,
// then scaled by the fraction bits with saturation. Depends on svf_pkg.
module svf_mul #(
  parameter int DATA_WIDTH = svf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = svf_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  svf_pkg::mul_ctrl_t           ctrl,
  input  logic signed [DATA_WIDTH-1:0] data,
  input  logic [svf_pkg::CFG_W-1:0]    coeff,
  output logic signed [DATA_WIDTH-1:0] result
);

  localparam int LO_W = DATA_WIDTH / 2;
  localparam int HI_W = DATA_WIDTH - LO_W;
  localparam int MA_W = HI_W + 1;
  localparam int MB_W = svf_pkg::CFG_W + 1;
  localparam int PP_W = MA_W + MB_W;
  localparam int PW   = DATA_WIDTH + MB_W;
  localparam int TOP_W = PW - DATA_WIDTH + 1;

  logic signed [MA_W-1:0] op_a;
  logic signed [MB_W-1:0] op_b;
  logic signed [PP_W-1:0] pp;
  logic signed [PP_W-1:0] pp_reg;
  logic signed [PW-1:0]   pp_ext;
  logic signed [PW-1:0]   acc;
  logic signed [PW-1:0]   scaled;
  logic [TOP_W-1:0]       top_bits;

  always_comb begin
    if (ctrl.hi_sel) begin
      op_a = $signed({data[DATA_WIDTH-1], data[DATA_WIDTH-1:LO_W]});
    end else begin
      op_a = $signed({{(MA_W-LO_W){1'b0}}, data[LO_W-1:0]});
    end
    op_b = $signed({1'b0, coeff});
    pp   = op_a * op_b;
  end

  assign pp_ext = PW'(pp_reg);

  always_ff @(posedge clk) begin
    pp_reg <= pp;
    if (ctrl.load_lo) begin
      acc <= pp_ext;
    end else if (ctrl.add_hi) begin
      acc <= acc + (pp_ext <<< LO_W);
    end
  end

  // Arithmetic shift floors; clamp to the data range.
  always_comb begin
    scaled   = acc >>> FRAC_BITS;
    top_bits = scaled[PW-1:DATA_WIDTH-1];
    if ((&top_bits) || !(|top_bits)) begin
      result = scaled[DATA_WIDTH-1:0];
    end else if (top_bits[TOP_W-1]) begin
      result = $signed({1'b1, {(DATA_WIDTH-1){1'b0}}});
    end else begin
      result = $signed({1'b0, {(DATA_WIDTH-1){1'b1}}});
    end
  end

endmodule
